### design/assert_macros.svh
// assertion helpers for the lexer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge out of reset
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");

`endif

### design/csl_pkg.sv
`default_nettype none
package csl_pkg;
  localparam int unsigned MaxTokenLen = 64;

  typedef enum logic [5:0] {
    K_END = 6'd0, K_ERROR = 6'd1, K_IDENT = 6'd2, K_INT = 6'd3, K_BOOL = 6'd4,
    K_VOID = 6'd5, K_KW_INT = 6'd6, K_KW_BOOL = 6'd7, K_IF = 6'd8, K_RETURN = 6'd9,
    K_LT = 6'd10, K_LE = 6'd11, K_GT = 6'd12, K_GE = 6'd13, K_ASSIGN = 6'd14,
    K_EQ = 6'd15, K_NE = 6'd16, K_PLUS = 6'd17, K_PLUS_EQ = 6'd18, K_INC = 6'd19,
    K_MINUS = 6'd20, K_MINUS_EQ = 6'd21, K_DEC = 6'd22, K_STAR = 6'd23,
    K_STAR_EQ = 6'd24, K_MOD = 6'd25, K_MOD_EQ = 6'd26, K_DIV = 6'd27,
    K_DIV_EQ = 6'd28, K_SEMI = 6'd29, K_COMMA = 6'd30, K_LPAREN = 6'd31,
    K_RPAREN = 6'd32, K_LBRACE = 6'd33, K_RBRACE = 6'd34, K_LBRACK = 6'd35,
    K_RBRACK = 6'd36
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_TOO_LONG = 3'd1, E_NUM_LETTER = 3'd2, E_LONE_BANG = 3'd3,
    E_BAD_BYTE = 3'd4
  } cause_t;

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001, M_WORD = 7'b0000010, M_NUMBER = 7'b0000100,
    M_OP = 7'b0001000, M_LINE = 7'b0010000, M_BLOCK = 7'b0100000,
    M_BLOCK_STAR = 7'b1000000
  } mode_t;

  typedef struct packed {
    kind_t kind;
    cause_t error_cause;
    logic [7:0] token_length;
    logic [15:0] start_row;
    logic [15:0] start_column;
    logic [31:0] start_offset;
  } token_t;

  // packed position: offset, row, column
  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] row;
    logic [15:0] col;
  } pos_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
endpackage
`default_nettype wire

### design/csl_in_if.sv
`default_nettype none
interface csl_in_if;
  logic valid;
  logic ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

### design/csl_out_if.sv
`default_nettype none
interface csl_out_if;
  logic valid;
  logic ready;
  logic [5:0] kind;
  logic [2:0] error_cause;
  logic [7:0] token_length;
  logic [15:0] start_row;
  logic [15:0] start_column;
  logic [31:0] start_offset;
  logic last;
  modport source (output valid, output kind, output error_cause, output token_length,
    output start_row, output start_column, output start_offset, output last, input ready);
  modport sink (input valid, input kind, input error_cause, input token_length,
    input start_row, input start_column, input start_offset, input last, output ready);
endinterface
`default_nettype wire

### design/csl_scan.sv
`default_nettype none
// per-byte scanner: state update plus up to two tokens
module csl_scan #(
  parameter int unsigned MAX_TOKEN_LEN = csl_pkg::MaxTokenLen
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire logic [7:0] ch,
  output csl_pkg::token_t tok0,
  output csl_pkg::token_t tok1,
  output logic [1:0] count
);
  import csl_pkg::*;

  mode_t mode_r, mode_nxt;
  logic [47:0] kbuf_r, kbuf_nxt;
  logic [7:0] run_r, run_nxt;
  logic letter_r, letter_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic [31:0] off_r;
  pos_t start_r, start_nxt;
  logic cr_r, seen_r;

  pos_t here;
  logic consumed;
  token_t t [2];
  logic [1:0] n;
  token_t wtok, otok, itok;
  logic iemit;
  logic [5:0] pk;
  logic lod;

  function automatic token_t mk(input kind_t k, input cause_t c, input logic [7:0] l,
                                input pos_t p);
    token_t r;
    r.kind = k; r.error_cause = c; r.token_length = l;
    r.start_row = p.row; r.start_column = p.col; r.start_offset = p.offset;
    return r;
  endfunction

  // word close
  always_comb begin
    kind_t k;
    cause_t c;
    k = K_IDENT;
    c = E_NONE;
    if (run_r >= 8'(MAX_TOKEN_LEN)) begin
      k = K_ERROR; c = E_TOO_LONG;
    end else if (mode_r == M_NUMBER) begin
      if (letter_r) begin
        k = K_ERROR; c = E_NUM_LETTER;
      end else begin
        k = K_INT;
      end
    end else if (run_r == 8'd4 && kbuf_r[31:0] == "void") k = K_VOID;
    else if (run_r == 8'd3 && kbuf_r[23:0] == "int") k = K_KW_INT;
    else if (run_r == 8'd4 && kbuf_r[31:0] == "bool") k = K_KW_BOOL;
    else if (run_r == 8'd2 && kbuf_r[15:0] == "if") k = K_IF;
    else if (run_r == 8'd6 && kbuf_r == "return") k = K_RETURN;
    else if (run_r == 8'd4 && kbuf_r[31:0] == "true") k = K_BOOL;
    else if (run_r == 8'd5 && kbuf_r[39:0] == "false") k = K_BOOL;
    wtok = mk(k, c, run_r, start_r);
  end

  // operator pair
  always_comb begin
    pk = 6'd0;
    if (ch == "=") begin
      case (pend_r)
        "<": pk = K_LE;
        ">": pk = K_GE;
        "=": pk = K_EQ;
        "!": pk = K_NE;
        "+": pk = K_PLUS_EQ;
        "-": pk = K_MINUS_EQ;
        "*": pk = K_STAR_EQ;
        "%": pk = K_MOD_EQ;
        "/": pk = K_DIV_EQ;
        default: pk = 6'd0;
      endcase
    end else if (pend_r == "+" && ch == "+") pk = K_INC;
    else if (pend_r == "-" && ch == "-") pk = K_DEC;
  end

  always_comb begin
    logic [15:0] r, c;
    kind_t sk;
    r = row_r;
    c = col_r;
    if (ch == 8'h0a && seen_r) begin
      if (r != 16'hffff) r = r + 16'd1;
      c = 16'd0;
      col_nxt = cr_r ? 16'd0 : 16'd1;
    end else if (ch == 8'h0d) begin
      col_nxt = c;
    end else begin
      col_nxt = (c == 16'hffff) ? c : c + 16'd1;
    end
    row_nxt = r;
    here.offset = off_r;
    here.row = r;
    here.col = c;

    mode_nxt = mode_r;
    kbuf_nxt = kbuf_r;
    run_nxt = run_r;
    letter_nxt = letter_r;
    pend_nxt = pend_r;
    start_nxt = start_r;
    consumed = 1'b0;
    n = 2'd0;
    t[0] = wtok;
    t[1] = wtok;
    lod = is_letter(ch) || is_digit(ch);

    case (pend_r)
      "<": sk = K_LT;
      ">": sk = K_GT;
      "=": sk = K_ASSIGN;
      "+": sk = K_PLUS;
      "-": sk = K_MINUS;
      "*": sk = K_STAR;
      "%": sk = K_MOD;
      default: sk = K_DIV;
    endcase
    otok = mk(sk, E_NONE, 8'd1, start_r);

    case (mode_r)
      M_WORD, M_NUMBER: begin
        if (lod) begin
          if (run_r < 8'd6) kbuf_nxt = {kbuf_r[39:0], ch};
          if (run_r != 8'hff) run_nxt = run_r + 8'd1;
          if (is_letter(ch)) letter_nxt = 1'b1;
          consumed = 1'b1;
        end else begin
          t[0] = wtok; n = 2'd1; mode_nxt = M_IDLE;
        end
      end
      M_OP: begin
        mode_nxt = M_IDLE;
        if (pend_r == "/" && ch == "/") begin
          mode_nxt = M_LINE; consumed = 1'b1;
        end else if (pend_r == "/" && ch == "*") begin
          mode_nxt = M_BLOCK_STAR; consumed = 1'b1;
        end else if (pk != 6'd0) begin
          t[0] = mk(kind_t'(pk), E_NONE, 8'd2, start_r); n = 2'd1; consumed = 1'b1;
        end else if (pend_r == "!") begin
          t[0] = mk(K_ERROR, E_LONE_BANG, 8'd1, start_r); n = 2'd1;
        end else begin
          t[0] = otok; n = 2'd1;
        end
      end
      M_LINE: begin
        if (ch == 8'h0a || ch == 8'h00) mode_nxt = M_IDLE;
        else consumed = 1'b1;
      end
      M_BLOCK, M_BLOCK_STAR: begin
        if (ch == 8'h00) mode_nxt = M_IDLE;
        else if (mode_r == M_BLOCK_STAR && ch == "/") begin
          mode_nxt = M_IDLE; consumed = 1'b1;
        end else begin
          mode_nxt = (ch == "*") ? M_BLOCK_STAR : M_BLOCK; consumed = 1'b1;
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    iemit = 1'b0;
    itok = mk(K_ERROR, E_BAD_BYTE, 8'd1, here);
    if (!consumed) begin
      case (ch) inside
        8'h20, 8'h09, 8'h0a, 8'h0d: iemit = 1'b0;
        8'h00: begin iemit = 1'b1; itok = mk(K_END, E_NONE, 8'd0, here); end
        "<", ">", "=", "!", "+", "-", "*", "%", "/": begin
          mode_nxt = M_OP; pend_nxt = ch; start_nxt = here;
        end
        ";": begin iemit = 1'b1; itok = mk(K_SEMI, E_NONE, 8'd1, here); end
        ",": begin iemit = 1'b1; itok = mk(K_COMMA, E_NONE, 8'd1, here); end
        "(": begin iemit = 1'b1; itok = mk(K_LPAREN, E_NONE, 8'd1, here); end
        ")": begin iemit = 1'b1; itok = mk(K_RPAREN, E_NONE, 8'd1, here); end
        "{": begin iemit = 1'b1; itok = mk(K_LBRACE, E_NONE, 8'd1, here); end
        "}": begin iemit = 1'b1; itok = mk(K_RBRACE, E_NONE, 8'd1, here); end
        "[": begin iemit = 1'b1; itok = mk(K_LBRACK, E_NONE, 8'd1, here); end
        "]": begin iemit = 1'b1; itok = mk(K_RBRACK, E_NONE, 8'd1, here); end
        default: begin
          if (lod) begin
            mode_nxt = is_letter(ch) ? M_WORD : M_NUMBER;
            start_nxt = here;
            kbuf_nxt = {40'd0, ch};
            run_nxt = 8'd1;
            letter_nxt = is_letter(ch);
          end else begin
            iemit = 1'b1;
          end
        end
      endcase
      if (iemit) begin
        if (n == 2'd0) t[0] = itok;
        else t[1] = itok;
        n = n + 2'd1;
      end
    end
  end

  assign tok0 = t[0];
  assign tok1 = t[1];
  assign count = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      kbuf_r <= '0; run_r <= '0; letter_r <= 1'b0; pend_r <= '0;
      row_r <= '0; col_r <= '0; off_r <= '0; start_r <= '0;
      cr_r <= 1'b0; seen_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      kbuf_r <= kbuf_nxt; run_r <= run_nxt; letter_r <= letter_nxt;
      pend_r <= pend_nxt; row_r <= row_nxt; col_r <= col_nxt;
      off_r <= off_r + 32'd1; start_r <= start_nxt;
      cr_r <= (ch == 8'h0d); seen_r <= 1'b1;
    end
  end
endmodule
`default_nettype wire

### design/csl_outq.sv
`default_nettype none
// four-entry result queue, two writes and one read per cycle
module csl_outq (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [1:0] wr_count,
  input  csl_pkg::token_t wr0,
  input  csl_pkg::token_t wr1,
  output logic has_room,
  csl_out_if.source out
);
  import csl_pkg::*;

  token_t q_r [4];
  logic l_r [4];
  logic [1:0] rp_r, wp_r;
  logic [2:0] cnt_r;
  logic pop;

  assign pop = out.valid && out.ready;
  // room for two more while keeping a full queue
  assign has_room = cnt_r <= 3'd2;
  assign out.valid = cnt_r != 3'd0;
  assign out.kind = q_r[rp_r].kind;
  assign out.error_cause = q_r[rp_r].error_cause;
  assign out.token_length = q_r[rp_r].token_length;
  assign out.start_row = q_r[rp_r].start_row;
  assign out.start_column = q_r[rp_r].start_column;
  assign out.start_offset = q_r[rp_r].start_offset;
  assign out.last = l_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      q_r[wp_r] <= wr0;
      l_r[wp_r] <= (wr_count == 2'd1);
    end
    if (wr_count == 2'd2) begin
      q_r[wp_r + 2'd1] <= wr1;
      l_r[wp_r + 2'd1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0; wp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + wr_count;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, wr_count} - {2'b0, pop};
    end
  end
endmodule
`default_nettype wire

### design/c_subset_lexer.sv
`default_nettype none
// a token is registered into the result queue when the byte that completes it is accepted
// throughput: one byte per cycle while the result queue has room for two
// a result queue of four entries holds tokens so input need not stall whenever out is not ready
// reset: synchronous active-low rst_n returns the scanner to idle, positions to zero
// and empties the result queue
module c_subset_lexer #(
  parameter int unsigned MAX_TOKEN_LEN = csl_pkg::MaxTokenLen
) (
  input wire logic clk,
  input wire logic rst_n,
  csl_in_if.sink in,
  csl_out_if.source out
);
  import csl_pkg::*;

  token_t tok0, tok1;
  logic [1:0] count;
  logic has_room;
  logic step;

  // accept whenever two queue slots are guaranteed free, never during reset
  assign in.ready = has_room && rst_n;
  assign step = in.valid && in.ready;

  csl_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan (
    .clk(clk), .rst_n(rst_n), .step(step), .ch(in.ch),
    .tok0(tok0), .tok1(tok1), .count(count)
  );

  // only an accepted byte writes results
  csl_outq u_outq (
    .clk(clk), .rst_n(rst_n),
    .wr_count(step ? count : 2'd0), .wr0(tok0), .wr1(tok1),
    .has_room(has_room), .out(out)
  );
endmodule
`default_nettype wire

### design/csl_checker.sv
`default_nettype none
`include "assert_macros.svh"
module csl_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [5:0] out_kind,
  input wire logic [2:0] out_error_cause,
  input wire logic [7:0] out_token_length
);
  import csl_pkg::*;

  `CHK_IMPLY(a_cause_err, clk, rst_n, out_valid && out_kind != K_ERROR, out_error_cause == E_NONE)
  `CHK_IMPLY(a_end_zero_len, clk, rst_n, out_valid && out_kind == K_END, out_token_length == 8'd0)
  `CHK_IMPLY(a_kind_range, clk, rst_n, out_valid, out_kind <= K_RBRACK)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind c_subset_lexer csl_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out.valid), .out_ready(out.ready), .out_kind(out.kind),
  .out_error_cause(out.error_cause), .out_token_length(out.token_length)
);
`default_nettype wire
